@@ design/tpe_pkg.sv @@
// shared types and constants for the tcp payload extractor
`timescale 1ns / 1ps

package tpe_pkg;

    // frame position counter width
    localparam int POS_W = 16;

    // header and payload start offset register widths
    localparam int NS_W = 5;
    localparam int TS_W = 7;
    localparam int PS_W = 8;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int PORT_W = 16;
    localparam logic [ADDR_W-3:0] REG_PORT_FILTER = 1'b0;

    // ethernet / ip / tcp constants
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;

    localparam logic [NS_W-1:0] ETH_HDR_BYTES  = 5'd14;
    localparam logic [NS_W-1:0] VLAN_HDR_BYTES = 5'd18;
    localparam logic [TS_W-1:0] IPV6_HDR_BYTES = 7'd40;
    localparam logic [3:0]      MIN_HDR_WORDS  = 4'd5;

    localparam int V4_PROTO_OFS   = 9;
    localparam int V6_NEXT_OFS    = 6;
    localparam int TCP_SRC_HI_OFS = 0;
    localparam int TCP_SRC_LO_OFS = 1;
    localparam int TCP_DST_HI_OFS = 2;
    localparam int TCP_DST_LO_OFS = 3;
    localparam int TCP_DOFF_OFS   = 12;

    typedef enum logic [2:0] {
        ST_PAYLOAD       = 3'd0,
        ST_NOT_IP        = 3'd1,
        ST_NOT_TCP       = 3'd2,
        ST_PORT_MISMATCH = 3'd3,
        ST_EMPTY         = 3'd4,
        ST_TRUNCATED     = 3'd5
    } tpe_status_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        is_payload;
        logic        frame_end;
        tpe_status_t frame_status;
    } tpe_result_t;

endpackage

@@ design/tpe_hdr_parser.sv @@
// header parser state and per-byte classification
`timescale 1ns / 1ps

module tpe_hdr_parser import tpe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        frame_byte,
    input  logic              frame_last,
    input  logic [PORT_W-1:0] port_filter,
    output tpe_result_t       result
);

    typedef enum logic [2:0] {
        PH_ETH     = 3'd0,
        PH_NET     = 3'd1,
        PH_TCP     = 3'd2,
        PH_PAY     = 3'd3,
        PH_NOT_IP  = 3'd4,
        PH_NOT_TCP = 3'd5,
        PH_PORT    = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       lt_reg, lt_next;
    logic [NS_W-1:0]   ns_reg, ns_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [15:0]       fp_reg, fp_next;
    logic              port_ok_reg, port_ok_next;
    logic [PS_W-1:0]   ps_reg, ps_next;

    logic [POS_W-1:0]  ns_ext;
    logic [POS_W-1:0]  rel_net;
    logic [POS_W-1:0]  rel_tcp;
    logic [POS_W-1:0]  ps_ext;
    logic [15:0]       lt_full;
    logic [15:0]       fp_full;
    logic              is_v4;
    logic [3:0]        ihl;
    logic [3:0]        doff;
    logic [POS_W-1:0]  proto_ofs;
    logic              pay;
    tpe_status_t       status;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        lt_next      = lt_reg;
        ns_next      = ns_reg;
        ts_next      = ts_reg;
        fp_next      = fp_reg;
        port_ok_next = port_ok_reg;
        ps_next      = ps_reg;

        ns_ext    = POS_W'(ns_reg);
        rel_net   = pos_reg - ns_ext;
        rel_tcp   = pos_reg - POS_W'(ts_reg);
        lt_full   = {lt_reg[15:8], frame_byte};
        fp_full   = {fp_reg[15:8], frame_byte};
        is_v4     = (lt_reg == ETYPE_IPV4);
        ihl       = (frame_byte[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : frame_byte[3:0];
        doff      = (frame_byte[7:4] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : frame_byte[7:4];
        proto_ofs = is_v4 ? POS_W'(V4_PROTO_OFS) : POS_W'(V6_NEXT_OFS);

        case (phase_reg)
            PH_ETH: begin
                if (pos_reg == ns_ext - POS_W'(2)) begin
                    lt_next = {frame_byte, 8'h00};
                end else if (pos_reg == ns_ext - POS_W'(1)) begin
                    lt_next = lt_full;
                    if (lt_full == ETYPE_VLAN && ns_reg == ETH_HDR_BYTES) begin
                        ns_next = VLAN_HDR_BYTES;
                    end else if (lt_full == ETYPE_IPV4 || lt_full == ETYPE_IPV6) begin
                        phase_next = PH_NET;
                    end else begin
                        phase_next = PH_NOT_IP;
                    end
                end
            end
            PH_NET: begin
                if (rel_net == '0) begin
                    ts_next = is_v4 ? (TS_W'(ns_reg) + TS_W'({ihl, 2'b00}))
                                    : (TS_W'(ns_reg) + IPV6_HDR_BYTES);
                end
                if (rel_net == proto_ofs && frame_byte != PROTO_TCP) begin
                    phase_next = PH_NOT_TCP;
                end else if (pos_reg == POS_W'(ts_next) - POS_W'(1)) begin
                    phase_next = PH_TCP;
                end
            end
            PH_TCP: begin
                if (rel_tcp == POS_W'(TCP_SRC_HI_OFS) || rel_tcp == POS_W'(TCP_DST_HI_OFS)) begin
                    fp_next = {frame_byte, 8'h00};
                end else if (rel_tcp == POS_W'(TCP_SRC_LO_OFS)) begin
                    fp_next      = fp_full;
                    port_ok_next = (port_filter == '0) || (fp_full == port_filter);
                end else if (rel_tcp == POS_W'(TCP_DST_LO_OFS)) begin
                    fp_next      = fp_full;
                    port_ok_next = port_ok_reg || (fp_full == port_filter);
                    if (!port_ok_next) begin
                        phase_next = PH_PORT;
                    end
                end else if (rel_tcp == POS_W'(TCP_DOFF_OFS)) begin
                    ps_next    = PS_W'(ts_reg) + PS_W'({doff, 2'b00});
                    phase_next = PH_PAY;
                end
            end
            default: begin
            end
        endcase

        ps_ext = POS_W'(ps_next);
        pay    = (phase_next == PH_PAY) && (pos_reg >= ps_ext);

        case (phase_next)
            PH_PAY: begin
                if (pos_reg >= ps_ext) begin
                    status = ST_PAYLOAD;
                end else if (pos_reg == ps_ext - POS_W'(1)) begin
                    status = ST_EMPTY;
                end else begin
                    status = ST_TRUNCATED;
                end
            end
            PH_NOT_IP:  status = ST_NOT_IP;
            PH_NOT_TCP: status = ST_NOT_TCP;
            PH_PORT:    status = ST_PORT_MISMATCH;
            default:    status = ST_TRUNCATED;
        endcase

        if (frame_last) begin
            phase_next   = PH_ETH;
            pos_next     = '0;
            lt_next      = '0;
            ns_next      = ETH_HDR_BYTES;
            ts_next      = '0;
            fp_next      = '0;
            port_ok_next = 1'b0;
            ps_next      = '0;
        end else if (pos_reg != '1) begin
            pos_next = pos_reg + POS_W'(1);
        end

        result.echo_byte    = frame_byte;
        result.is_payload   = pay;
        result.frame_end    = frame_last;
        result.frame_status = frame_last ? status : ST_PAYLOAD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_ETH;
            pos_reg     <= '0;
            lt_reg      <= '0;
            ns_reg      <= ETH_HDR_BYTES;
            ts_reg      <= '0;
            fp_reg      <= '0;
            port_ok_reg <= 1'b0;
            ps_reg      <= '0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            lt_reg      <= lt_next;
            ns_reg      <= ns_next;
            ts_reg      <= ts_next;
            fp_reg      <= fp_next;
            port_ok_reg <= port_ok_next;
            ps_reg      <= ps_next;
        end
    end

`ifndef SYNTHESIS
    // a finished frame leaves the parser at its start state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && frame_last) |=> (pos_reg == '0 && phase_reg == PH_ETH
                                     && ns_reg == ETH_HDR_BYTES))
        else $error("parser state not cleared after last byte");

    // a payload byte that ends a frame always reports payload status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && result.is_payload && result.frame_end)
            |-> (result.frame_status == ST_PAYLOAD))
        else $error("payload byte at frame end with non-payload status");

    // the vlan start is only reached through the ethernet phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ns_reg != ETH_HDR_BYTES) |-> (ns_reg == VLAN_HDR_BYTES))
        else $error("network start holds an unexpected offset");
`endif

endmodule

@@ design/tpe_out_buf.sv @@
// two-entry result buffer with skid slot
`timescale 1ns / 1ps

module tpe_out_buf import tpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  tpe_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tpe_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    tpe_result_t main_reg, main_next;
    tpe_result_t skid_reg, skid_next;
    logic        push;
    logic        pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg) begin
            main_valid_next = push;
            main_next       = in_data;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_next       = in_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    // skid slot only fills behind a held head item
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without head entry");

    // an item arriving under a stall is caught in the skid slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready && !skid_valid_reg && in_valid)
            |=> (skid_valid_reg && main_valid_reg))
        else $error("item lost under output stall");
`endif

endmodule

@@ design/tcp_payload_extractor_core.sv @@
// top level of the tcp payload extractor: config port, parser and result buffer
`timescale 1ns / 1ps

// tcp payload extractor
// s_ channel: one frame byte per item (s_frame_byte) with s_frame_last on the
//   final byte; valid/ready handshake, an item moves when both are high
// m_ channel: exactly one result item per input item, in order: the byte echoed,
//   a payload flag, frame_end copied from frame_last, and a status code on the
//   last byte (payload, not ip, not tcp, port mismatch, empty, truncated)
// apb port: one register, port_filter at byte address 0; zero passes every port
// buffering: each result is registered in the result buffer before it is offered on m_
// throughput: one item per cycle while s_ready is high; the per-byte header parse is a single
//   combinational step from the parser state registers into the result buffer
// stall: a two-entry result buffer keeps s_ready high for one more item while
//   m_ready is low; s_ready drops only when both entries are full
// reset: synchronous active-low aresetn clears the parser to the start of a
//   frame, empties the result buffer and sets port_filter to zero
module tcp_payload_extractor_core import tpe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_frame_byte,
    input  logic              s_frame_last,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_echo_byte,
    output logic              m_is_payload,
    output logic              m_frame_end,
    output logic [2:0]        m_frame_status,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [PORT_W-1:0] port_filter_reg;
    logic              filter_sel;
    logic              in_fire;
    tpe_result_t       parse_res;
    tpe_result_t       out_res;

    // register decode: word index from the upper address bits
    assign filter_sel = (paddr[ADDR_W-1:2] == REG_PORT_FILTER);
    assign pready     = 1'b1;
    assign prdata     = filter_sel ? DATA_W'(port_filter_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_filter_reg <= '0;
        end else if (psel && penable && pwrite && pready && filter_sel) begin
            port_filter_reg <= pwdata[PORT_W-1:0];
        end
    end

    // an accepted byte advances the parser and enters the result buffer
    assign in_fire = s_valid && s_ready;

    tpe_hdr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .frame_byte  (s_frame_byte),
        .frame_last  (s_frame_last),
        .port_filter (port_filter_reg),
        .result      (parse_res)
    );

    tpe_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (parse_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    // result fields onto their own ports
    assign m_echo_byte    = out_res.echo_byte;
    assign m_is_payload   = out_res.is_payload;
    assign m_frame_end    = out_res.frame_end;
    assign m_frame_status = out_res.frame_status;

endmodule
